// ===== rtl/clt_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath interface structs
// for the closed tour length block; no dependencies
package clt_pkg;

  localparam int MAX_TOWNS_DEFAULT = 256;

  localparam int IDX_W      = 8;
  localparam int COORD_W    = 16;
  localparam int SUM_W      = 33;
  // dx*dx + dy*dy of 17-bit differences
  localparam int SQ_W       = 2 * COORD_W + 1;
  // scale by 2^16 before the root gives 8 fractional bits
  localparam int FRAC_SHIFT = 16;
  // radicand padded by one bit so it splits into whole bit pairs
  localparam int RAD_W      = SQ_W + FRAC_SHIFT + 1;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_ORDER = 1'b1;

  typedef enum logic [1:0] {
    SEL_PREV,
    SEL_CUR,
    SEL_FIRST
  } rd_sel_t;

  typedef struct packed {
    logic    ram_wr;
    logic    start_tour;
    logic    take_item;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    latch_a;
    logic    diff;
    logic    square_x;
    logic    square_y;
    logic    sqrt_start;
    logic    accumulate;
    logic    advance_prev;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/clt_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module clt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/clt_sqrt.sv =====
`timescale 1ns / 1ps
// iterative integer square root, one result bit per cycle
// depends on clt_pkg
module clt_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [clt_pkg::RAD_W-1:0]  radicand,
  output logic                       busy,
  output logic [clt_pkg::ROOT_W-1:0] root
);

  import clt_pkg::*;

  localparam int STEP_W = $clog2(SQRT_STEPS);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] count;
  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  // bring down the next bit pair and try root*4+1
  assign cur   = {rem, rad[RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign diff  = cur - trial;
  assign ge    = (cur >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= STEP_W'(SQRT_STEPS - 1);
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (ge) begin
        rem  <= diff[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= cur[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/clt_datapath.sv =====
`timescale 1ns / 1ps
// datapath: coordinate store, difference and square, root, saturating sum
// and output register; depends on clt_pkg, clt_ram, clt_sqrt
module clt_datapath #(
  parameter int MAX_TOWNS = clt_pkg::MAX_TOWNS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  clt_pkg::cmd_t                     cmd,
  output clt_pkg::status_t                  status,
  input  logic [clt_pkg::IDX_W-1:0]         town_index,
  input  logic signed [clt_pkg::COORD_W-1:0] coord_x,
  input  logic signed [clt_pkg::COORD_W-1:0] coord_y,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [clt_pkg::SUM_W-1:0]         tour_length
);

  import clt_pkg::*;

  localparam int AW = (MAX_TOWNS > 1) ? $clog2(MAX_TOWNS) : 1;

  logic [IDX_W-1:0]          first_town;
  logic [IDX_W-1:0]          prev_town;
  logic [IDX_W-1:0]          cur_idx;
  logic [IDX_W-1:0]          rd_idx;
  logic                      rd_ok;
  logic                      wr_ok;
  logic [2*COORD_W-1:0]      ram_rdata;
  logic signed [COORD_W-1:0] b_x;
  logic signed [COORD_W-1:0] b_y;
  logic signed [COORD_W-1:0] a_x;
  logic signed [COORD_W-1:0] a_y;
  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic signed [COORD_W:0]   mul_op;
  logic signed [SQ_W:0]      sq_full;
  logic [SQ_W-1:0]           prod;
  logic [SQ_W-1:0]           sq_sum;
  logic [SQ_W:0]             rad_sum;
  logic [RAD_W-1:0]          radicand;
  logic                      sqrt_busy;
  logic [ROOT_W-1:0]         root;
  logic [SUM_W-1:0]          length_sum;
  logic [SUM_W:0]            acc;

  assign wr_ok = (int'(town_index) < MAX_TOWNS);

  always_comb begin
    case (cmd.rd_sel)
      SEL_PREV:  rd_idx = prev_town;
      SEL_CUR:   rd_idx = cur_idx;
      SEL_FIRST: rd_idx = first_town;
      default:   rd_idx = prev_town;
    endcase
  end

  clt_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_TOWNS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.ram_wr && wr_ok),
    .waddr (AW'(town_index)),
    .wdata ({coord_x, coord_y}),
    .re    (cmd.rd_en),
    .raddr (AW'(rd_idx)),
    .rdata (ram_rdata)
  );

  // towns beyond the store read as the origin
  assign b_x = rd_ok ? ram_rdata[2*COORD_W-1:COORD_W] : '0;
  assign b_y = rd_ok ? ram_rdata[COORD_W-1:0] : '0;

  assign mul_op  = cmd.square_y ? dy : dx;
  assign sq_full = mul_op * mul_op;

  assign rad_sum  = {1'b0, sq_sum} + {1'b0, prod};
  assign radicand = {1'b0, rad_sum[SQ_W-1:0], {FRAC_SHIFT{1'b0}}};

  clt_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .root     (root)
  );

  assign acc = {1'b0, length_sum} + (SUM_W + 1)'(root);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_ok <= (int'(rd_idx) < MAX_TOWNS);
    end
    if (cmd.latch_a) begin
      a_x <= b_x;
      a_y <= b_y;
    end
    if (cmd.diff) begin
      dx <= {a_x[COORD_W-1], a_x} - {b_x[COORD_W-1], b_x};
      dy <= {a_y[COORD_W-1], a_y} - {b_y[COORD_W-1], b_y};
    end
    if (cmd.square_x) begin
      prod <= sq_full[SQ_W-1:0];
    end
    if (cmd.square_y) begin
      sq_sum <= prod;
      prod   <= sq_full[SQ_W-1:0];
    end
    if (cmd.take_item) begin
      cur_idx <= town_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_town <= '0;
      prev_town  <= '0;
      length_sum <= '0;
    end else begin
      if (cmd.start_tour) begin
        first_town <= town_index;
        prev_town  <= town_index;
        length_sum <= '0;
      end
      if (cmd.accumulate) begin
        length_sum <= acc[SUM_W] ? '1 : acc[SUM_W-1:0];
      end
      if (cmd.advance_prev) begin
        prev_town <= cur_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tour_length <= length_sum;
    end
  end

  assign status.sqrt_busy = sqrt_busy;
  assign status.out_busy  = out_valid && !out_ready;

endmodule

// ===== rtl/clt_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences loads, tour legs and the closing leg
// depends on clt_pkg
module clt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  input  logic             last,
  input  clt_pkg::status_t status,
  output clt_pkg::cmd_t    cmd
);

  import clt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT_START,
    ST_ROOT_WAIT,
    ST_ACC,
    ST_RESULT
  } state_t;

  state_t state;
  logic   started;
  logic   closing;
  logic   item_last;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_LOAD) begin
          cmd.ram_wr = 1'b1;
        end
        if (accept && kind == KIND_ORDER) begin
          cmd.start_tour = !started;
          cmd.take_item  = started;
        end
      end
      ST_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_PREV;
      end
      ST_RD_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = closing ? SEL_FIRST : SEL_CUR;
        cmd.latch_a = 1'b1;
      end
      ST_DIFF:       cmd.diff       = 1'b1;
      ST_SQ_X:       cmd.square_x   = 1'b1;
      ST_SQ_Y:       cmd.square_y   = 1'b1;
      ST_ROOT_START: cmd.sqrt_start = 1'b1;
      ST_ROOT_WAIT:  cmd            = '0;
      ST_ACC: begin
        cmd.accumulate   = 1'b1;
        cmd.advance_prev = !closing;
      end
      ST_RESULT:     cmd.emit       = !status.out_busy;
      default:       cmd            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      started   <= 1'b0;
      closing   <= 1'b0;
      item_last <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && kind == KIND_ORDER) begin
            item_last <= last;
            closing   <= 1'b0;
            if (started) begin
              state <= ST_RD_A;
            end else if (last) begin
              // a one-town tour has length zero
              state <= ST_RESULT;
            end else begin
              started <= 1'b1;
            end
          end
        end
        ST_RD_A:       state <= ST_RD_B;
        ST_RD_B:       state <= ST_DIFF;
        ST_DIFF:       state <= ST_SQ_X;
        ST_SQ_X:       state <= ST_SQ_Y;
        ST_SQ_Y:       state <= ST_ROOT_START;
        ST_ROOT_START: state <= ST_ROOT_WAIT;
        ST_ROOT_WAIT: begin
          if (!status.sqrt_busy) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (closing) begin
            state <= ST_RESULT;
          end else if (item_last) begin
            // leg back to the first town
            closing <= 1'b1;
            state   <= ST_RD_A;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RESULT: begin
          if (!status.out_busy) begin
            started <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/closed_tour_length.sv =====
`timescale 1ns / 1ps
// Closed tour length evaluator. Load transactions (kind 0) write a town's
// signed x/y into a coordinate ram. Order transactions (kind 1) stream town
// indices; every index after the first adds the distance from the previous
// town, floor(sqrt((dx^2 + dy^2) * 2^16)), so lengths carry 8 fractional
// bits. The transaction flagged last also adds the leg back to the first
// town and delivers the 33-bit saturated sum (zero for a single town). Each
// later order transaction holds the block through two ram reads, the
// difference, the squaring and the 25-step bit-serial square root; the last
// one then runs the closing leg alike and loads the output register. Input
// is taken while a finished total waits at the output. Indices at or above
// MAX_TOWNS read as the origin; loads there are dropped. Reading a town
// that was never loaded gives undefined lengths.
// depends on clt_pkg, clt_ctrl, clt_datapath
module closed_tour_length #(
  parameter int MAX_TOWNS = clt_pkg::MAX_TOWNS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic [clt_pkg::IDX_W-1:0]          town_index,
  input  logic signed [clt_pkg::COORD_W-1:0] coord_x,
  input  logic signed [clt_pkg::COORD_W-1:0] coord_y,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [clt_pkg::SUM_W-1:0]          tour_length
);

  import clt_pkg::*;

  cmd_t    cmd;
  status_t status;

  clt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .last     (last),
    .status   (status),
    .cmd      (cmd)
  );

  clt_datapath #(
    .MAX_TOWNS (MAX_TOWNS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .town_index  (town_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .tour_length (tour_length)
  );

`ifndef SYNTH
  // a total is only written into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("total written over an undelivered result");

  // a delivered result clears unless a new total arrives
  a_out_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !cmd.emit) |=> !out_valid)
    else $error("result delivered twice");

  // the root unit is never restarted mid-run
  a_sqrt_start: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |-> !status.sqrt_busy)
    else $error("square root restarted while busy");

  // no new transaction while a leg is in flight
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.sqrt_busy)
    else $error("input taken during a root computation");
`endif

endmodule
